[design/bb3_pkg.sv]
// shared constants, codes and types of the 3x3 box blur
`default_nettype none

package bb3_pkg;

  // pixel and register widths
  localparam int PIX_W      = 8;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int ROW_W      = 12;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  // frame geometry
  localparam int DEF_MAX_WIDTH = 4096;
  localparam int HEIGHT_LIMIT  = 4096;
  localparam int RESET_SIZE    = 512;

  // divide by nine as multiply by a reciprocal and shift
  localparam int SUM_W       = 12;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;
  localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;
  localparam int PROD_W      = SUM_W + RECIP_W;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // operation kinds handed from front to back
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_PIX   = 2'd0;
  localparam logic [OP_W-1:0] OP_UPPER = 2'd1;
  localparam logic [OP_W-1:0] OP_LOWER = 2'd2;

  // one classified operation
  typedef struct packed {
    logic [OP_W-1:0]  kind;
    logic [PIX_W-1:0] pix;
    logic             produce;
    logic             use_sum;
    logic             last;
  } op_t;

endpackage

`default_nettype wire

[design/bb3_if.sv]
// valid/ready channel interfaces for pixels in and results out
`default_nettype none

interface bb3_in_if import bb3_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [PIX_W-1:0] in_pixel;

  modport source (output valid, output action, output in_pixel, input ready);
  modport sink   (input valid, input action, input in_pixel, output ready);
endinterface

interface bb3_out_if import bb3_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_pixel;
  logic             frame_last;

  modport source (output valid, output out_pixel, output frame_last, input ready);
  modport sink   (input valid, input out_pixel, input frame_last, output ready);
endinterface

`default_nettype wire

[design/bb3_front.sv]
// front end: frame geometry registers, position tracking and classification
`default_nettype none

module bb3_front import bb3_pkg::*; #(
  parameter int  MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int AW        = $clog2(MAX_WIDTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 accept,
  input  logic                 action,
  input  logic [PIX_W-1:0]     pixel,
  output logic                 push,
  output logic [AW-1:0]        push_addr,
  output op_t                  push_op
);

  localparam int W_RST = ((RESET_SIZE < MAX_WIDTH) ? RESET_SIZE : MAX_WIDTH) - 1;
  localparam int H_RST = RESET_SIZE - 1;

  logic [AW-1:0]    wlast_r, wlast_nxt;
  logic [ROW_W-1:0] hlast_r, hlast_nxt;
  logic [AW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             all_in_r, all_in_nxt;
  logic             up_pend_r, up_pend_nxt;
  logic             restart;

  // classify the transfer and advance the frame position
  always_comb begin
    col_nxt          = col_r;
    row_nxt          = row_r;
    all_in_nxt       = all_in_r;
    up_pend_nxt      = up_pend_r;
    wlast_nxt        = wlast_r;
    hlast_nxt        = hlast_r;
    restart          = 1'b0;
    push             = 1'b0;
    push_addr        = col_r;
    push_op.kind     = OP_PIX;
    push_op.pix      = pixel;
    push_op.produce  = (row_r > ROW_W'(1)) || ((row_r == ROW_W'(1)) && (col_r != '0));
    push_op.use_sum  = (row_r > ROW_W'(1)) && (col_r > AW'(1));
    push_op.last     = 1'b0;

    if (accept) begin
      if (action) begin
        // flush tick: drain one pending result once the frame is in
        if (all_in_r) begin
          push = 1'b1;
          if (up_pend_r) begin
            push_op.kind = OP_UPPER;
            push_addr    = wlast_r;
            up_pend_nxt  = 1'b0;
          end else begin
            push_op.kind = OP_LOWER;
            push_op.last = (col_r == wlast_r);
            if (col_r == wlast_r) begin
              restart = 1'b1;
            end else begin
              col_nxt = col_r + AW'(1);
            end
          end
        end
      end else if (!all_in_r) begin
        // new pixel of the frame
        push = 1'b1;
        if (col_r == wlast_r) begin
          col_nxt = '0;
          if (row_r == hlast_r) begin
            row_nxt     = '0;
            all_in_nxt  = 1'b1;
            up_pend_nxt = (hlast_r != '0);
          end else begin
            row_nxt = row_r + ROW_W'(1);
          end
        end else begin
          col_nxt = col_r + AW'(1);
        end
      end
    end

    // register writes, clamped to the legal range
    if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          restart = 1'b1;
          if (cfg_wdata == '0) begin
            wlast_nxt = '0;
          end else if (32'(cfg_wdata) > MAX_WIDTH) begin
            wlast_nxt = AW'(MAX_WIDTH - 1);
          end else begin
            wlast_nxt = AW'(cfg_wdata - CFG_W'(1));
          end
        end
        CFG_IMAGE_HEIGHT: begin
          restart = 1'b1;
          if (cfg_wdata == '0) begin
            hlast_nxt = '0;
          end else if (32'(cfg_wdata) > HEIGHT_LIMIT) begin
            hlast_nxt = ROW_W'(HEIGHT_LIMIT - 1);
          end else begin
            hlast_nxt = ROW_W'(cfg_wdata - CFG_W'(1));
          end
        end
        default: ;
      endcase
    end

    // back to the first pixel of a new frame
    if (restart) begin
      col_nxt     = '0;
      row_nxt     = '0;
      all_in_nxt  = 1'b0;
      up_pend_nxt = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlast_r   <= AW'(W_RST);
      hlast_r   <= ROW_W'(H_RST);
      col_r     <= '0;
      row_r     <= '0;
      all_in_r  <= 1'b0;
      up_pend_r <= 1'b0;
    end else begin
      wlast_r   <= wlast_nxt;
      hlast_r   <= hlast_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      all_in_r  <= all_in_nxt;
      up_pend_r <= up_pend_nxt;
    end
  end

endmodule

`default_nettype wire

[design/bb3_queue.sv]
// small register queue between front and back
`default_nettype none

module bb3_queue import bb3_pkg::*; #(
  parameter int  DW    = 8,
  parameter int  DEPTH = QUEUE_DEPTH,
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output logic [DW-1:0] head_data
);

  logic [DW-1:0] slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[design/bb3_back.sv]
// back end: line store, window, sum, divide by nine and output register
`default_nettype none

module bb3_back import bb3_pkg::*; #(
  parameter int  MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int AW        = $clog2(MAX_WIDTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  logic [AW-1:0]    head_addr,
  input  op_t              head_op,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] out_pixel,
  output logic             out_last
);

  localparam int MW = 2 * PIX_W;

  // both line stores share one entry: upper row high, lower row low
  logic [MW-1:0]    mem [MAX_WIDTH];
  logic [MW-1:0]    rdata_r;

  logic             adv;
  logic             s1_valid_r;
  logic [AW-1:0]    s1_addr_r;
  op_t              s1_op_r;
  logic             s1_fwd_r;
  logic [MW-1:0]    s1_fwd_data_r;

  logic [MW-1:0]    entry;
  logic [PIX_W-1:0] up_pix, lo_pix;
  logic             wr_en;
  logic [MW-1:0]    wdata;
  logic [PIX_W-1:0] win_r [6];
  logic [SUM_W-1:0] sum;
  logic             emit;
  logic [PIX_W-1:0] pass;

  logic             s2_valid_r;
  logic [SUM_W-1:0] s2_sum_r;
  logic [PIX_W-1:0] s2_pass_r;
  logic             s2_use_sum_r;
  logic             s2_last_r;
  logic [PROD_W-1:0] prod;

  logic             out_valid_r;
  logic [PIX_W-1:0] out_pixel_r;
  logic             out_last_r;

  // whole back pipe moves unless a result waits at the output
  assign adv = !out_valid_r || out_ready;
  assign pop = adv && head_valid;

  // line store read, registered
  always_ff @(posedge clk) begin
    if (adv) begin
      rdata_r <= mem[head_addr];
    end
  end

  // line store write from the second stage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_addr_r] <= wdata;
    end
  end

  // first stage: operation travels alongside the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= pop;
    end
  end

  // bypass the entry written in the same cycle it is read
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_addr_r     <= head_addr;
      s1_op_r       <= head_op;
      s1_fwd_r      <= wr_en && (head_addr == s1_addr_r);
      s1_fwd_data_r <= wdata;
    end
  end

  // second stage: stored rows, window and nine-term sum
  assign entry  = s1_fwd_r ? s1_fwd_data_r : rdata_r;
  assign up_pix = entry[MW-1:PIX_W];
  assign lo_pix = entry[PIX_W-1:0];
  assign wr_en  = adv && s1_valid_r && (s1_op_r.kind == OP_PIX);
  assign wdata  = {lo_pix, s1_op_r.pix};

  always_comb begin
    sum = SUM_W'(up_pix) + SUM_W'(lo_pix) + SUM_W'(s1_op_r.pix);
    for (int i = 0; i < 6; i++) begin
      sum = sum + SUM_W'(win_r[i]);
    end
  end

  // pick pass-through value and whether a result leaves
  always_comb begin
    case (s1_op_r.kind)
      OP_PIX: begin
        emit = s1_op_r.produce;
        pass = win_r[4];
      end
      OP_UPPER: begin
        emit = 1'b1;
        pass = up_pix;
      end
      OP_LOWER: begin
        emit = 1'b1;
        pass = lo_pix;
      end
      default: begin
        emit = 1'b0;
        pass = lo_pix;
      end
    endcase
  end

  // window columns shift on every pixel
  always_ff @(posedge clk) begin
    if (wr_en) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= up_pix;
      win_r[4] <= lo_pix;
      win_r[5] <= s1_op_r.pix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sum_r     <= sum;
      s2_pass_r    <= pass;
      s2_use_sum_r <= (s1_op_r.kind == OP_PIX) && s1_op_r.use_sum;
      s2_last_r    <= (s1_op_r.kind == OP_LOWER) && s1_op_r.last;
    end
  end

  // third stage: divide by nine, then the output register
  assign prod = PROD_W'(s2_sum_r) * PROD_W'(RECIP_9);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pixel_r <= s2_use_sum_r ? prod[RECIP_SHIFT +: PIX_W] : s2_pass_r;
      out_last_r  <= s2_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

[design/box_blur_3x3_gray.sv]
// top level of the streaming 3x3 box blur for 8-bit gray frames
//
//   channel   direction  transfer when          payload
//   in_ch     in         valid & ready          action, in_pixel
//   out_ch    out        valid & ready          out_pixel, frame_last
//   cfg_*     in         cfg_we                 cfg_index, cfg_wdata
//
// one item per clock sustained while the output is not stalled; a result passes
// from the pixel or flush tick that causes it through the queue, the line store
// read, the sum stage and the divide-by-nine stage into the output register.
// synchronous reset clears counters, queue and valid flags; line stores keep
// whatever they hold, with no clearing pass. a stall at the output freezes the
// back end; the front keeps taking transfers until the queue fills.
`default_nettype none

module box_blur_3x3_gray import bb3_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  bb3_in_if.sink               in_ch,
  bb3_out_if.source            out_ch
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int QW = AW + $bits(op_t);

  logic          accept;
  logic          push;
  logic [AW-1:0] push_addr;
  op_t           push_op;
  logic          q_full;
  logic          q_pop;
  logic          head_valid;
  logic [QW-1:0] head_data;
  logic [AW-1:0] head_addr;
  op_t           head_op;

  // input transfer
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  bb3_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .action    (in_ch.action),
    .pixel     (in_ch.in_pixel),
    .push      (push),
    .push_addr (push_addr),
    .push_op   (push_op)
  );

  bb3_queue #(
    .DW    (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  ({push_addr, push_op}),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  // split the queue word back into address and operation
  assign head_addr = head_data[QW-1 -: AW];
  assign head_op   = head_data[$bits(op_t)-1:0];

  bb3_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_addr  (head_addr),
    .head_op    (head_op),
    .pop        (q_pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_pixel  (out_ch.out_pixel),
    .out_last   (out_ch.frame_last)
  );

endmodule

`default_nettype wire

[design/bb3_checker.sv]
// port-level checks of the box blur, bound to the top level
`default_nettype none

module bb3_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_frame_last
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // reset empties the back end
  a_rst_no_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // reset empties the queue, so input is taken at once
  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready right after reset");

  // first pixels of a new frame never make a result
  a_gap_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_frame_last |=> !out_valid)
    else $error("result right after end of frame");

endmodule

bind box_blur_3x3_gray bb3_checker u_bb3_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_frame_last (out_ch.frame_last)
);

`default_nettype wire
